@@ sv/fpa_pkg.sv @@
package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 4;
    localparam int FRAC_BITS_DEF = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
    localparam logic [OP_W-1:0] OP_MIN      = 4'd4;
    localparam logic [OP_W-1:0] OP_MAX      = 4'd5;
    localparam logic [OP_W-1:0] OP_INC      = 4'd6;
    localparam logic [OP_W-1:0] OP_DEC      = 4'd7;
    localparam logic [OP_W-1:0] OP_TO_INT   = 4'd8;
    localparam logic [OP_W-1:0] OP_FROM_INT = 4'd9;

    // per-transaction data that travels beside the divider
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
        logic              neg;
    } side_t;

endpackage

@@ sv/fpa_mul.sv @@
module fpa_mul
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic        [DATA_W-1:0] val
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] shifted;

    // full product, then arithmetic shift and truncation
    assign shifted = prod_reg >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign val = shifted[DATA_W-1:0];

endmodule

@@ sv/fpa_div.sv @@
module fpa_div
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [DATA_W+FRAC_BITS-1:0]  dividend,
    input  logic [DATA_W-1:0]            divisor,
    output logic [DATA_W-1:0]            quotient
);

    localparam int DW = DATA_W + FRAC_BITS;

    logic [DATA_W-1:0] rem_reg [DW];
    logic [DW-1:0]     nq_reg  [DW];
    logic [DATA_W-1:0] d_reg   [DW];

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DW; i++) begin : g_stage
        logic [DATA_W-1:0] rem_in;
        logic [DW-1:0]     nq_in;
        logic [DATA_W-1:0] d_in;
        logic [DATA_W:0]   trial;
        logic [DATA_W:0]   diff;
        logic              ge;
        logic [DATA_W-1:0] rem_next;
        logic [DW-1:0]     nq_next;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
            assign d_in   = divisor;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        always_comb begin
            trial    = {rem_in, nq_in[DW-1]};
            diff     = trial - {1'b0, d_in};
            ge       = (trial >= {1'b0, d_in});
            rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            nq_next  = {nq_in[DW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= nq_next;
                d_reg[i]   <= d_in;
            end
        end
    end

    assign quotient = nq_reg[DW-1][DATA_W-1:0];

endmodule

@@ sv/fixed_point_alu.sv @@
// pipeline from input transaction to result: input register, operand and flag register, divider stages, output register
// throughput: one transaction per cycle when not stalled; the divider resolves one quotient bit per stage
// the whole pipeline advances together and holds while the result waits for m_ready
// reset: synchronous active-low aresetn clears all stage valid bits; data is not reset
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_operation,
    input  logic signed [DATA_W-1:0] s_operand_a,
    input  logic signed [DATA_W-1:0] s_operand_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic                     m_a_less,
    output logic                     m_a_equal,
    output logic                     m_a_greater,
    output logic                     m_divide_by_zero
);

    localparam int DW  = DATA_W + FRAC_BITS;
    localparam int LAT = DW + 3;

    logic                     en;
    logic [LAT-1:0]           vld_reg;
    logic [LAT-1:0]           vld_next;

    logic [OP_W-1:0]          op1_reg;
    logic signed [DATA_W-1:0] a1_reg;
    logic signed [DATA_W-1:0] b1_reg;

    side_t                    side2_next;
    side_t                    side2_reg;
    logic [DW-1:0]            dn2_reg;
    logic [DATA_W-1:0]        dd2_reg;
    logic [DATA_W-1:0]        abs_a;
    logic [DATA_W-1:0]        abs_b;

    side_t                    side3_next;
    side_t                    side_reg [DW];
    logic [DATA_W-1:0]        mul_val;
    logic [DATA_W-1:0]        div_q;

    side_t                    last;
    logic [DATA_W-1:0]        out_next;
    logic [DATA_W-1:0]        val_reg;
    logic                     lt_reg;
    logic                     eq_reg;
    logic                     gt_reg;
    logic                     dz_reg;

    // global advance: move when the output slot is empty or being taken
    assign en       = !vld_reg[LAT-1] || m_ready;
    assign s_ready  = en;
    assign vld_next = {vld_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= s_operation;
            a1_reg  <= s_operand_a;
            b1_reg  <= s_operand_b;
        end
    end

    // simple operations, flags and divider operand setup
    always_comb begin
        abs_a = a1_reg[DATA_W-1] ? DATA_W'(-a1_reg) : DATA_W'(a1_reg);
        abs_b = b1_reg[DATA_W-1] ? DATA_W'(-b1_reg) : DATA_W'(b1_reg);

        side2_next.op  = op1_reg;
        side2_next.lt  = (a1_reg < b1_reg);
        side2_next.eq  = (a1_reg == b1_reg);
        side2_next.gt  = (a1_reg > b1_reg);
        side2_next.dz  = (op1_reg == OP_DIV) && (b1_reg == '0);
        side2_next.neg = a1_reg[DATA_W-1] ^ b1_reg[DATA_W-1];

        case (op1_reg)
            OP_ADD:      side2_next.val = DATA_W'(a1_reg + b1_reg);
            OP_SUB:      side2_next.val = DATA_W'(a1_reg - b1_reg);
            OP_MIN:      side2_next.val = (a1_reg < b1_reg) ? a1_reg : b1_reg;
            OP_MAX:      side2_next.val = (a1_reg > b1_reg) ? a1_reg : b1_reg;
            OP_INC:      side2_next.val = DATA_W'(a1_reg + 1);
            OP_DEC:      side2_next.val = DATA_W'(a1_reg - 1);
            OP_TO_INT:   side2_next.val = DATA_W'(a1_reg >>> FRAC_BITS);
            OP_FROM_INT: side2_next.val = DATA_W'(a1_reg <<< FRAC_BITS);
            default:     side2_next.val = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            dn2_reg   <= DW'(abs_a) << FRAC_BITS;
            dd2_reg   <= abs_b;
        end
    end

    fpa_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .aclk(aclk),
        .en  (en),
        .a   (a1_reg),
        .b   (b1_reg),
        .val (mul_val)
    );

    fpa_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .en      (en),
        .dividend(dn2_reg),
        .divisor (dd2_reg),
        .quotient(div_q)
    );

    // merge the product, then delay beside the divider
    always_comb begin
        side3_next = side2_reg;
        if (side2_reg.op == OP_MUL) begin
            side3_next.val = mul_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side3_next;
            for (int i = 1; i < DW; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // final select and output register
    assign last = side_reg[DW-1];

    always_comb begin
        if (last.op == OP_DIV) begin
            if (last.dz) begin
                out_next = '0;
            end else begin
                out_next = last.neg ? DATA_W'(-div_q) : div_q;
            end
        end else begin
            out_next = last.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            val_reg <= out_next;
            lt_reg  <= last.lt;
            eq_reg  <= last.eq;
            gt_reg  <= last.gt;
            dz_reg  <= last.dz;
        end
    end

    assign m_valid          = vld_reg[LAT-1];
    assign m_value          = val_reg;
    assign m_a_less         = lt_reg;
    assign m_a_equal        = eq_reg;
    assign m_a_greater      = gt_reg;
    assign m_divide_by_zero = dz_reg;

    // a divide by a zero divisor always returns zero
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_value == '0)
        else $error("divide by zero with nonzero value");

    // exactly one comparison flag per result
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_a_less, m_a_equal, m_a_greater}))
        else $error("comparison flags not one-hot");

    // a stalled pipeline keeps every stage valid bit
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during stall");

    // the divide flag only comes from a divide
    a_dz_op: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] && last.dz |-> last.op == OP_DIV)
        else $error("divide flag on non-divide operation");

endmodule

@@ sim/tb_fixed_point_alu.sv @@
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int LATENCY   = FRAC + 35;
    localparam int N_RANDOM  = 400;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     lt;
        logic                     eq;
        logic                     gt;
        logic                     dz;
    } alu_rsp_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation;
    logic signed [DATA_W-1:0] s_operand_a;
    logic signed [DATA_W-1:0] s_operand_b;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_value;
    logic                     m_a_less;
    logic                     m_a_equal;
    logic                     m_a_greater;
    logic                     m_divide_by_zero;

    alu_req_t pending_ops[$];
    alu_rsp_t expected_results[$];
    int       mismatches;
    int       results_seen;
    int       cycles;
    int       send_gap;
    int       recv_gap;

    fixed_point_alu i_dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle length: none half the time, otherwise mostly short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // expected alu answer for one transaction
    function automatic alu_rsp_t alu_predict(alu_req_t t);
        alu_rsp_t         r;
        logic signed [63:0] wide;
        logic signed [63:0] num;
        r = '0;
        r.lt = t.a < t.b;
        r.eq = t.a == t.b;
        r.gt = t.a > t.b;
        case (t.op)
            OP_ADD:      r.value = t.a + t.b;
            OP_SUB:      r.value = t.a - t.b;
            OP_MUL: begin
                wide = 64'(t.a) * 64'(t.b);
                r.value = 32'(wide >>> FRAC);
            end
            OP_DIV: begin
                if (t.b == 0) begin
                    r.dz = 1'b1;
                    r.value = '0;
                end else begin
                    num = 64'(t.a) <<< FRAC;
                    r.value = 32'(num / 64'(t.b));
                end
            end
            OP_MIN:      r.value = (t.a < t.b) ? t.a : t.b;
            OP_MAX:      r.value = (t.a > t.b) ? t.a : t.b;
            OP_INC:      r.value = t.a + 1;
            OP_DEC:      r.value = t.a - 1;
            OP_TO_INT:   r.value = t.a >>> FRAC;
            OP_FROM_INT: r.value = t.a << FRAC;
            default:     r.value = '0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // stimulus: directed corners then random transactions
    initial begin
        alu_req_t t;
        logic [31:0] corners[6];
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
        for (int op = 0; op < 16; op++) begin
            t.op = OP_W'(op);
            t.a = corners[op % 6];
            t.b = corners[(op + 1) % 6];
            pending_ops.push_back(t);
        end
        pending_ops.push_back('{OP_DIV, 32'sh0000_0300, 32'sh0});
        pending_ops.push_back('{OP_DIV, 32'sh8000_0000, 32'shffff_ff00});
        pending_ops.push_back('{OP_MUL, 32'sh8000_0000, 32'sh8000_0000});
        pending_ops.push_back('{OP_MIN, 32'sh0000_0005, 32'sh0000_0005});
        pending_ops.push_back('{OP_TO_INT, 32'shffff_ff01, 32'sh0});
        pending_ops.push_back('{OP_INC, 32'sh7fff_ffff, 32'sh0});
        pending_ops.push_back('{OP_DEC, 32'sh8000_0000, 32'sh0});
        for (int i = 0; i < N_RANDOM; i++) begin
            t.op = ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(10, 15))
                                                : OP_W'($urandom_range(0, 9));
            t.a = rand_operand();
            t.b = ($urandom_range(0, 3) == 0) ? t.a : rand_operand();
            if (t.op == OP_DIV && $urandom_range(0, 9) == 0) t.b = '0;
            pending_ops.push_back(t);
        end
    end

    // reset
    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_operation <= '0;
            s_operand_a <= '0;
            s_operand_b <= '0;
            send_gap    <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(alu_predict({s_operation, s_operand_a, s_operand_b}));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_ops.size() > 0) begin
                    alu_req_t t;
                    t = pending_ops.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= t.op;
                    s_operand_a <= t.a;
                    s_operand_b <= t.b;
                    send_gap    <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                alu_rsp_t got;
                alu_rsp_t want;
                got = {m_value, m_a_less, m_a_equal, m_a_greater, m_divide_by_zero};
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: value %h/%h lt %b/%b eq %b/%b gt %b/%b dz %b/%b",
                                want.value, got.value, want.lt, got.lt, want.eq, got.eq,
                                want.gt, got.gt, want.dz, got.dz);
                    end
                end
            end
            if (recv_gap > 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_ready  <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // end of run
    initial begin
        #1;
        while ((pending_ops.size() > 0 || s_valid || expected_results.size() > 0)
               && cycles < CYCLE_CAP)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
        if (cycles >= CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end else begin
            $display("checked %0d alu results over all operation codes, %0d mismatches",
                results_seen, mismatches);
            if (mismatches == 0 && expected_results.size() == 0) begin
                $display("simulation ok");
            end else begin
                $display("simulation failed");
            end
            $finish;
        end
    end

endmodule
